[rtl/obdx_pkg.sv]
// Shared types, codes and a helper function of the OBD reply payload extractor.
package obdx_pkg;

    // Header byte offset and the service mode that carries a record index.
    localparam logic [7:0] HDR_OFFSET      = 8'h40;
    localparam logic [7:0] MODE_WITH_INDEX = 8'h09;

    // Character codes the tokenizer looks for.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X_LO  = 8'h78;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;

    // Result queue depth and its occupancy counter width.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_CW    = 3;

    // Configuration register indexes.
    localparam logic [1:0] REG_REQUEST_MODE = 2'd0;
    localparam logic [1:0] REG_REQUEST_PID  = 2'd1;
    localparam logic [1:0] REG_WANTED_LEN   = 2'd2;

    // Parse state of the token being collected.
    typedef enum logic [2:0] {
        FORM_EMPTY   = 3'd0,
        FORM_ZERO    = 3'd1,
        FORM_AFTER_X = 3'd2,
        FORM_DIGITS  = 3'd3,
        FORM_DONE    = 3'd4,
        FORM_BAD     = 3'd5,
        FORM_COLON   = 3'd6
    } form_t;

    // A token closed by the tokenizer.
    typedef struct packed {
        logic        valid;
        logic [31:0] value;
    } obdx_tok_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] request_mode;
        logic [7:0] request_pid;
        logic [7:0] wanted_len;
    } obdx_cfg_t;

    // One result item.
    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic       success;
        logic [7:0] bytes_out;
        logic       last_result;
    } obdx_res_t;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

[rtl/obdx_token.sv]
// Tokenizer: collects characters into a hex token and closes it on a delimiter or end of reply.
module obdx_token (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            reply_char,
    input  logic                  end_of_reply,
    output obdx_pkg::obdx_tok_t   tok
);

    obdx_pkg::form_t form_reg, form_next, form_fed;
    logic [31:0]     value_reg, value_next, value_fed;
    logic [4:0]      dig;
    logic            is_delim;
    logic            closing;
    obdx_pkg::form_t close_form;

    // Feed one non-delimiter character into the token.
    always_comb begin
        dig       = obdx_pkg::hex_digit(reply_char);
        form_fed  = form_reg;
        value_fed = value_reg;
        if (reply_char == obdx_pkg::CHAR_COLON) begin
            form_fed = obdx_pkg::FORM_COLON;
        end else begin
            unique case (form_reg)
                obdx_pkg::FORM_EMPTY: begin
                    if (!dig[4]) begin
                        form_fed = obdx_pkg::FORM_BAD;
                    end else begin
                        value_fed = {28'd0, dig[3:0]};
                        form_fed  = (reply_char == obdx_pkg::CHAR_ZERO) ?
                                    obdx_pkg::FORM_ZERO : obdx_pkg::FORM_DIGITS;
                    end
                end
                obdx_pkg::FORM_ZERO: begin
                    if (reply_char == obdx_pkg::CHAR_X_LO ||
                        reply_char == obdx_pkg::CHAR_X_UP) begin
                        form_fed = obdx_pkg::FORM_AFTER_X;
                    end else if (dig[4]) begin
                        value_fed = {28'd0, dig[3:0]};
                        form_fed  = obdx_pkg::FORM_DIGITS;
                    end else begin
                        form_fed = obdx_pkg::FORM_DONE;
                    end
                end
                obdx_pkg::FORM_AFTER_X: begin
                    if (dig[4]) begin
                        value_fed = {28'd0, dig[3:0]};
                        form_fed  = obdx_pkg::FORM_DIGITS;
                    end else begin
                        form_fed = obdx_pkg::FORM_DONE;
                    end
                end
                obdx_pkg::FORM_DIGITS: begin
                    if (dig[4]) begin
                        value_fed = {value_reg[27:0], dig[3:0]};
                    end else begin
                        form_fed = obdx_pkg::FORM_DONE;
                    end
                end
                default: begin
                    form_fed = form_reg;
                end
            endcase
        end
    end

    // Close the token on a delimiter, or after feeding the final character.
    always_comb begin
        is_delim = (reply_char == obdx_pkg::CHAR_SPACE) ||
                   (reply_char == obdx_pkg::CHAR_CR) ||
                   (reply_char == obdx_pkg::CHAR_LF);
        closing    = accept && (is_delim || end_of_reply);
        close_form = is_delim ? form_reg : form_fed;
        tok.value  = is_delim ? value_reg : value_fed;
        tok.valid  = closing && (close_form == obdx_pkg::FORM_ZERO ||
                                 close_form == obdx_pkg::FORM_AFTER_X ||
                                 close_form == obdx_pkg::FORM_DIGITS ||
                                 close_form == obdx_pkg::FORM_DONE);
        form_next  = form_reg;
        value_next = value_reg;
        if (closing) begin
            form_next  = obdx_pkg::FORM_EMPTY;
            value_next = 32'd0;
        end else if (accept) begin
            form_next  = form_fed;
            value_next = value_fed;
        end
    end

    // Token registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            form_reg  <= obdx_pkg::FORM_EMPTY;
            value_reg <= 32'd0;
        end else begin
            form_reg  <= form_next;
            value_reg <= value_next;
        end
    end

endmodule

[rtl/obdx_frame.sv]
// Header search and payload copy: turns closed tokens into payload and status results.
module obdx_frame #(
    parameter int MAX_TOKENS = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic                           end_of_reply,
    input  obdx_pkg::obdx_tok_t            tok,
    input  obdx_pkg::obdx_cfg_t            cfg,
    output obdx_pkg::obdx_res_t [2:0]      res,
    output logic [1:0]                     res_count
);

    localparam int SeenW = $clog2(MAX_TOKENS + 1);

    logic [31:0]      prev_tok_reg, prev_tok_next;
    logic             prev_v_reg, prev_v_next;
    logic             copy_reg, copy_next;
    logic             skip_reg, skip_next;
    logic [7:0]       pend_reg, pend_next;
    logic             pend_v_reg, pend_v_next;
    logic [SeenW-1:0] seen_reg, seen_next;
    logic [7:0]       copied_reg, copied_next;

    logic [7:0]       hdr_mode;
    logic             indexed;
    logic             done;
    logic             ok;

    // One token step, then end-of-reply flush and status.
    always_comb begin
        hdr_mode      = cfg.request_mode + obdx_pkg::HDR_OFFSET;
        indexed       = (cfg.request_mode == obdx_pkg::MODE_WITH_INDEX);
        prev_tok_next = prev_tok_reg;
        prev_v_next   = prev_v_reg;
        copy_next     = copy_reg;
        skip_next     = skip_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        seen_next     = seen_reg;
        copied_next   = copied_reg;
        res           = '0;
        res_count     = 2'd0;
        done          = 1'b0;
        ok            = 1'b0;

        if (tok.valid && seen_reg < SeenW'(MAX_TOKENS)) begin
            seen_next = seen_reg + 1'b1;
            if (!copy_reg) begin
                // Header search on consecutive token pairs.
                if (prev_v_reg && prev_tok_reg == {24'd0, hdr_mode} &&
                    tok.value == {24'd0, cfg.request_pid}) begin
                    copy_next = 1'b1;
                    skip_next = indexed;
                end else begin
                    prev_tok_next = tok.value;
                    prev_v_next   = 1'b1;
                end
            end else if (skip_reg) begin
                skip_next = 1'b0;
            end else begin
                // A held header byte is either a repeated header or payload.
                if (pend_v_reg) begin
                    pend_v_next = 1'b0;
                    if (tok.value == {24'd0, cfg.request_pid}) begin
                        skip_next = indexed;
                        done      = 1'b1;
                    end else if (copied_next < cfg.wanted_len) begin
                        res[res_count].payload_byte = pend_reg;
                        res_count   = res_count + 1'b1;
                        copied_next = copied_next + 1'b1;
                    end
                end
                if (!done && copied_next < cfg.wanted_len) begin
                    if (tok.value == {24'd0, hdr_mode}) begin
                        pend_next   = hdr_mode;
                        pend_v_next = 1'b1;
                    end else begin
                        res[res_count].payload_byte = tok.value[7:0];
                        res_count   = res_count + 1'b1;
                        copied_next = copied_next + 1'b1;
                    end
                end
            end
        end

        if (accept && end_of_reply) begin
            // A header byte still held at the end goes out as payload.
            if (pend_v_next && copied_next < cfg.wanted_len) begin
                res[res_count].payload_byte = pend_next;
                res_count   = res_count + 1'b1;
                copied_next = copied_next + 1'b1;
            end
            ok = copy_next && (seen_next >= SeenW'(3)) && (copied_next == cfg.wanted_len);
            res[res_count].result_kind = 1'b1;
            res[res_count].success     = ok;
            res[res_count].bytes_out   = copied_next;
            res[res_count].last_result = 1'b1;
            res_count = res_count + 1'b1;
            // Start the next reply from a clean state.
            prev_tok_next = 32'd0;
            prev_v_next   = 1'b0;
            copy_next     = 1'b0;
            skip_next     = 1'b0;
            pend_next     = 8'd0;
            pend_v_next   = 1'b0;
            seen_next     = '0;
            copied_next   = 8'd0;
        end
    end

    // Reply state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_tok_reg <= 32'd0;
            prev_v_reg   <= 1'b0;
            copy_reg     <= 1'b0;
            skip_reg     <= 1'b0;
            pend_reg     <= 8'd0;
            pend_v_reg   <= 1'b0;
            seen_reg     <= '0;
            copied_reg   <= 8'd0;
        end else begin
            prev_tok_reg <= prev_tok_next;
            prev_v_reg   <= prev_v_next;
            copy_reg     <= copy_next;
            skip_reg     <= skip_next;
            pend_reg     <= pend_next;
            pend_v_reg   <= pend_v_next;
            seen_reg     <= seen_next;
            copied_reg   <= copied_next;
        end
    end

endmodule

[rtl/obdx_rsq.sv]
// Result queue: takes up to three results a cycle and hands them out one item at a time.
module obdx_rsq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  obdx_pkg::obdx_res_t [2:0]     push_res,
    input  logic [1:0]                    push_count,
    output logic                          space_ok,
    output obdx_pkg::obdx_res_t           head,
    output logic                          head_valid,
    input  logic                          head_ready
);

    obdx_pkg::obdx_res_t q_reg   [obdx_pkg::QUEUE_DEPTH];
    obdx_pkg::obdx_res_t q_next  [obdx_pkg::QUEUE_DEPTH];
    obdx_pkg::obdx_res_t q_shift [obdx_pkg::QUEUE_DEPTH];
    logic [obdx_pkg::QUEUE_CW-1:0] count_reg, count_next, base, rel;
    logic pop;

    // Room for a full burst of results decides whether a new item may enter.
    assign space_ok   = (count_reg <= obdx_pkg::QUEUE_CW'(obdx_pkg::QUEUE_DEPTH - 3));
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[0];
    assign pop        = head_valid && head_ready;

    // Shift out the head on a pop, then append the new results behind the rest.
    always_comb begin
        base = count_reg - {{(obdx_pkg::QUEUE_CW-1){1'b0}}, pop};
        for (int i = 0; i < obdx_pkg::QUEUE_DEPTH - 1; i++) begin
            q_shift[i] = pop ? q_reg[i+1] : q_reg[i];
        end
        q_shift[obdx_pkg::QUEUE_DEPTH-1] = q_reg[obdx_pkg::QUEUE_DEPTH-1];
        for (int i = 0; i < obdx_pkg::QUEUE_DEPTH; i++) begin
            rel       = obdx_pkg::QUEUE_CW'(i) - base;
            q_next[i] = q_shift[i];
            if (obdx_pkg::QUEUE_CW'(i) >= base &&
                obdx_pkg::QUEUE_CW'(i) < base + {1'b0, push_count}) begin
                q_next[i] = push_res[rel[1:0]];
            end
        end
        count_next = base + {1'b0, push_count};
    end

    // Queue entry registers; they hold payload and status results.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < obdx_pkg::QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    // Occupancy counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/obd_hex_reply_payload_extractor.sv]
// Top level of the OBD hex reply payload extractor: config registers, tokenizer, framer, queue.
//
//   Port group  Dir  Carries
//   s_*         in   reply characters; tdata = reply_char, tlast = end_of_reply
//   m_*         out  results; tdata = payload_byte, success, bytes_out; tuser = result_kind;
//                    tlast = last_result
//   cfg_*       in   register writes; cfg_index selects mode, pid or wanted length
//
// One character is taken per cycle while s_tready is high; its token and header update finish in that cycle.
// A character yields up to three results, which wait in a four-entry queue; s_tready is
// high while the queue has room for three, so one result per character streams at full rate.
// Reset is synchronous and active low; it clears the reply state and loads register defaults.
// A stall on m_tready backs up the queue, which then lowers s_tready; config writes are taken every cycle.
module obd_hex_reply_payload_extractor #(
    parameter int MAX_TOKENS = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] reply_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [8] success, [16:9] bytes_out, zeros above
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    obdx_pkg::obdx_cfg_t        cfg_reg, cfg_next;
    obdx_pkg::obdx_tok_t        tok;
    obdx_pkg::obdx_res_t [2:0]  res;
    obdx_pkg::obdx_res_t        head;
    logic [1:0]                 res_count;
    logic                       accept;
    logic                       space_ok;

    assign s_tready  = space_ok;
    assign accept    = s_tvalid && space_ok;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                obdx_pkg::REG_REQUEST_MODE: cfg_next.request_mode = cfg_data;
                obdx_pkg::REG_REQUEST_PID:  cfg_next.request_pid  = cfg_data;
                obdx_pkg::REG_WANTED_LEN:   cfg_next.wanted_len   = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.request_mode <= 8'd1;
            cfg_reg.request_pid  <= 8'd0;
            cfg_reg.wanted_len   <= 8'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Character tokenizer.
    obdx_token u_token (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .reply_char   (s_tdata),
        .end_of_reply (s_tlast),
        .tok          (tok)
    );

    // Header search and payload copy.
    obdx_frame #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .end_of_reply (s_tlast),
        .tok          (tok),
        .cfg          (cfg_reg),
        .res          (res),
        .res_count    (res_count)
    );

    // Result queue toward the output channel.
    obdx_rsq u_rsq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_res   (res),
        .push_count (res_count),
        .space_ok   (space_ok),
        .head       (head),
        .head_valid (m_tvalid),
        .head_ready (m_tready)
    );

    // Pack the head result onto the output channel.
    assign m_tdata = {7'd0, head.bytes_out, head.success, head.payload_byte};
    assign m_tuser = head.result_kind;
    assign m_tlast = head.last_result;

endmodule
